[hw/rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the JSON string unescaper
// Decode modes, result status codes, the command handed from the decoder to
// the result sequencer, and the command queue geometry.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_STR  = 2'd1,
      MODE_ESC  = 2'd2,
      MODE_HEX  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_DATA   = 3'd0,
      ST_CLOSED = 3'd1,
      ST_NOOPEN = 3'd2,
      ST_UNTERM = 3'd3,
      ST_BADHEX = 3'd4
   } status_type;

   // One command covers every result caused by one source byte:
   // n_data data bytes (data[0] first), then an optional status marker.
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      n_data;
      logic            has_term;
      status_type      term;
   } cmd_type;

   localparam int QDEPTH  = 4;
   localparam int Q_PTR_W = $clog2(QDEPTH);
   localparam int Q_CNT_W = $clog2(QDEPTH + 1);

endpackage

[hw/rtl/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front: source byte decoder
// Tracks the string/escape/hex state, assembles \u code points and turns each
// accepted byte that yields results into one command for the result sequencer.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   input  logic             q_full,
   output logic             push,
   output jsu_pkg::cmd_type cmd
);

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [1:0]        seen_ff, seen_in;
   logic [15:0]       cp_ff, cp_in;
   logic              accept;
   logic [4:0]        hexv;
   logic [15:0]       cp_next;

   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic [7:0] map_escape(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h62:   r = 8'h08;
         8'h66:   r = 8'h0C;
         8'h6E:   r = 8'h0A;
         8'h72:   r = 8'h0D;
         8'h74:   r = 8'h09;
         default: r = b;
      endcase
      return r;
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign hexv       = hex_value(req_tdata);
   assign cp_next    = {cp_ff[11:0], hexv[3:0]};

   always_comb begin
      mode_in      = mode_ff;
      seen_in      = seen_ff;
      cp_in        = cp_ff;
      cmd          = '0;
      cmd.term     = jsu_pkg::ST_DATA;
      case (mode_ff)
         jsu_pkg::MODE_IDLE: begin
            cmd.has_term = 1'b1;
            if (req_tdata == 8'h22) begin
               if (req_tlast) begin
                  cmd.term = jsu_pkg::ST_UNTERM;
               end else begin
                  cmd.has_term = 1'b0;
                  mode_in      = jsu_pkg::MODE_STR;
               end
            end else begin
               cmd.term = jsu_pkg::ST_NOOPEN;
            end
         end
         jsu_pkg::MODE_STR: begin
            if (req_tdata == 8'h22) begin
               cmd.has_term = 1'b1;
               cmd.term     = jsu_pkg::ST_CLOSED;
               mode_in      = jsu_pkg::MODE_IDLE;
            end else begin
               if (req_tdata == 8'h5C) begin
                  mode_in = jsu_pkg::MODE_ESC;
               end else begin
                  cmd.n_data  = 2'd1;
                  cmd.data[0] = req_tdata;
               end
               if (req_tlast) begin
                  cmd.has_term = 1'b1;
                  cmd.term     = jsu_pkg::ST_UNTERM;
                  mode_in      = jsu_pkg::MODE_IDLE;
               end
            end
         end
         jsu_pkg::MODE_ESC: begin
            if (req_tdata == 8'h75) begin
               mode_in = jsu_pkg::MODE_HEX;
               seen_in = 2'd0;
               cp_in   = 16'd0;
            end else begin
               cmd.n_data  = 2'd1;
               cmd.data[0] = map_escape(req_tdata);
               mode_in     = jsu_pkg::MODE_STR;
            end
            if (req_tlast) begin
               cmd.has_term = 1'b1;
               cmd.term     = jsu_pkg::ST_UNTERM;
               mode_in      = jsu_pkg::MODE_IDLE;
            end
         end
         jsu_pkg::MODE_HEX: begin
            if (!hexv[4]) begin
               cmd.has_term = 1'b1;
               cmd.term     = jsu_pkg::ST_BADHEX;
               mode_in      = jsu_pkg::MODE_IDLE;
            end else if (req_tlast) begin
               cmd.has_term = 1'b1;
               cmd.term     = jsu_pkg::ST_UNTERM;
               mode_in      = jsu_pkg::MODE_IDLE;
            end else begin
               cp_in = cp_next;
               if (seen_ff == 2'd3) begin
                  mode_in = jsu_pkg::MODE_STR;
                  seen_in = 2'd0;
                  // encode the finished code point as UTF-8
                  if (cp_next < 16'h0080) begin
                     cmd.n_data  = 2'd1;
                     cmd.data[0] = cp_next[7:0];
                  end else if (cp_next < 16'h0800) begin
                     cmd.n_data  = 2'd2;
                     cmd.data[0] = 8'hC0 | {3'd0, cp_next[10:6]};
                     cmd.data[1] = 8'h80 | {2'd0, cp_next[5:0]};
                  end else begin
                     cmd.n_data  = 2'd3;
                     cmd.data[0] = 8'hE0 | {4'd0, cp_next[15:12]};
                     cmd.data[1] = 8'h80 | {2'd0, cp_next[11:6]};
                     cmd.data[2] = 8'h80 | {2'd0, cp_next[5:0]};
                  end
               end else begin
                  seen_in = seen_ff + 2'd1;
               end
            end
         end
         default: begin
            mode_in = jsu_pkg::MODE_IDLE;
         end
      endcase
      if (mode_in == jsu_pkg::MODE_IDLE) begin
         seen_in = 2'd0;
         cp_in   = 16'd0;
      end
   end

   assign push = accept && (cmd.has_term || (cmd.n_data != 2'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jsu_pkg::MODE_IDLE;
         seen_ff <= 2'd0;
         cp_ff   <= 16'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         seen_ff <= seen_in;
         cp_ff   <= cp_in;
      end
   end

   // hex digit count only moves while collecting \u digits
   a_seen_idle: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != jsu_pkg::MODE_HEX) |-> (seen_ff == 2'd0))
      else $error("hex digit count nonzero outside hex mode");

   a_idle_cp: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == jsu_pkg::MODE_IDLE) |-> (cp_ff == 16'd0))
      else $error("code point not cleared while idle");

   a_push_ready: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("command pushed into full queue");

endmodule

[hw/rtl/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue: command queue
// Small FIFO between the decoder and the result sequencer so that either
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
module jsu_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  jsu_pkg::cmd_type        push_cmd,
   input  logic                    pop,
   output jsu_pkg::cmd_type        head_cmd,
   output logic                    not_empty,
   output logic                    full
);

   jsu_pkg::cmd_type                 mem_ff [jsu_pkg::QDEPTH];
   logic [jsu_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::Q_CNT_W-1:0]      count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == jsu_pkg::Q_CNT_W'(jsu_pkg::QDEPTH));
   assign head_cmd  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= jsu_pkg::Q_CNT_W'(jsu_pkg::QDEPTH))
      else $error("queue count above depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("pointers differ while queue is empty");

endmodule

[hw/rtl/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back: result sequencer
// Holds one command and plays out its data bytes and status marker, one result
// transfer per cycle while rsp_tready is high, flagging the final one with tlast.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::cmd_type head_cmd,
   input  logic             not_empty,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tlast
);

   jsu_pkg::cmd_type cmd_ff, cmd_in;
   logic             valid_ff, valid_in;
   logic [1:0]       idx_ff, idx_in;
   logic [1:0]       total;
   logic             final_one;
   logic             in_data;

   assign total     = cmd_ff.n_data + {1'b0, cmd_ff.has_term};
   assign final_one = (idx_ff == total - 2'd1);
   assign in_data   = (idx_ff < cmd_ff.n_data);

   always_comb begin
      rsp_tdata = 8'h00;
      rsp_tuser = cmd_ff.term;
      if (in_data) begin
         rsp_tuser = jsu_pkg::ST_DATA;
         case (idx_ff)
            2'd0:    rsp_tdata = cmd_ff.data[0];
            2'd1:    rsp_tdata = cmd_ff.data[1];
            2'd2:    rsp_tdata = cmd_ff.data[2];
            default: rsp_tdata = 8'h00;
         endcase
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = final_one;

   // load the next command once the current one has gone out, or when none is held
   assign pop = not_empty && (!valid_ff || (rsp_tready && final_one));

   always_comb begin
      cmd_in   = cmd_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pop) begin
         cmd_in   = head_cmd;
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (valid_ff && rsp_tready) begin
         if (final_one) begin
            valid_in = 1'b0;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   a_nonempty_cmd: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (total != 2'd0))
      else $error("held command carries no result");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < total))
      else $error("result index past command end");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_tuser != jsu_pkg::ST_DATA) |-> rsp_tlast)
      else $error("status marker not final result of its byte");

endmodule

[hw/rtl/json_string_unescape.sv]
// ----------------------------------------------------------------------------
// json_string_unescape: JSON string unescaper with UTF-8 output
// Decodes a JSON string from its opening quote, one source byte per transfer,
// into decoded bytes plus closing and error markers.
//
//   Channel  Direction  Payload
//   req_     in         tdata[7:0] source byte, tlast final source byte
//   rsp_     out        tdata[7:0] decoded byte, tuser[2:0] status,
//                       tlast final result of one source byte
//
// One source byte is taken per cycle while the command queue has room.
// Each byte yields zero to three results; the sequencer sends one per
// cycle while rsp_tready is high, so a \u escape (six bytes, up to three
// results) keeps the full rate.
// A stalled rsp_ side fills the four-entry queue, then drops req_tready.
// Synchronous active-high reset returns the decoder to waiting for a quote.
// ----------------------------------------------------------------------------
module json_string_unescape (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [2:0] out_status
   output logic       rsp_tlast
);

   jsu_pkg::cmd_type push_cmd;
   jsu_pkg::cmd_type head_cmd;
   logic             push;
   logic             pop;
   logic             not_empty;
   logic             q_full;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (not_empty),
      .full      (q_full)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .not_empty  (not_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for json_string_unescape
// Streams source bytes into req_, predicts the decoded bytes and markers for
// every accepted transfer, and checks each rsp_ transfer in order. Directed
// tests cover idle bytes, escapes, \u forms and truncated or bad strings;
// a random test mixes well-formed strings with noise and broken strings
// while both sides stall at random.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   typedef struct {
      logic [7:0]          data;
      jsu_pkg::status_type status;
      logic                last;
   } decoded_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   // decoder image
   jsu_pkg::mode_type dec_mode = jsu_pkg::MODE_IDLE;
   logic [1:0]        hex_cnt  = 2'd0;
   logic [15:0]       cp_acc   = 16'h0000;

   decoded_type decoded_due[$];
   decoded_type step_out[$];
   decoded_type head;
   int          mismatches = 0;
   int          bytes_sent = 0;
   bit          calm       = 1'b0;
   int          hold_req   = 0;

   json_string_unescape dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [3:0] rand_nibble();
      return 4'($urandom_range(0, 15));
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
      if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h61 + 8'd10)};
      if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h41 + 8'd10)};
      return 5'b0_0000;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] escape_byte(input logic [7:0] b);
      case (b)
         8'h62:   return 8'h08;  // b
         8'h66:   return 8'h0C;  // f
         8'h6E:   return 8'h0A;  // n
         8'h72:   return 8'h0D;  // r
         8'h74:   return 8'h09;  // t
         default: return b;
      endcase
   endfunction

   task automatic emit(input logic [7:0] d, input jsu_pkg::status_type st);
      decoded_type r;
      r.data   = d;
      r.status = st;
      r.last   = 1'b0;
      step_out = {step_out, r};
   endtask

   // Advance the decoder image by one source byte; queue its results.
   task automatic unescape_byte(input logic [7:0] b, input logic lst);
      logic [4:0]  nib;
      decoded_type r;
      int          i;
      step_out.delete();
      case (dec_mode)
         jsu_pkg::MODE_IDLE: begin
            if (b == CH_QUOTE) begin
               if (lst) emit(8'h00, jsu_pkg::ST_UNTERM);
               else dec_mode = jsu_pkg::MODE_STR;
            end else begin
               emit(8'h00, jsu_pkg::ST_NOOPEN);
            end
         end
         jsu_pkg::MODE_STR: begin
            if (b == CH_QUOTE) begin
               emit(8'h00, jsu_pkg::ST_CLOSED);
               dec_mode = jsu_pkg::MODE_IDLE;
            end else begin
               if (b == CH_BSLASH) dec_mode = jsu_pkg::MODE_ESC;
               else emit(b, jsu_pkg::ST_DATA);
               if (lst) begin
                  emit(8'h00, jsu_pkg::ST_UNTERM);
                  dec_mode = jsu_pkg::MODE_IDLE;
               end
            end
         end
         jsu_pkg::MODE_ESC: begin
            if (b == CH_U) begin
               dec_mode = jsu_pkg::MODE_HEX;
               hex_cnt  = 2'd0;
               cp_acc   = 16'h0000;
            end else begin
               emit(escape_byte(b), jsu_pkg::ST_DATA);
               dec_mode = jsu_pkg::MODE_STR;
            end
            if (lst) begin
               emit(8'h00, jsu_pkg::ST_UNTERM);
               dec_mode = jsu_pkg::MODE_IDLE;
            end
         end
         default: begin
            nib = hex_nibble(b);
            if (!nib[4]) begin
               emit(8'h00, jsu_pkg::ST_BADHEX);
               dec_mode = jsu_pkg::MODE_IDLE;
            end else if (lst) begin
               // drop the partial or complete code point
               emit(8'h00, jsu_pkg::ST_UNTERM);
               dec_mode = jsu_pkg::MODE_IDLE;
            end else begin
               cp_acc = {cp_acc[11:0], nib[3:0]};
               if (hex_cnt == 2'd3) begin
                  if (cp_acc < 16'h0080) begin
                     emit(cp_acc[7:0], jsu_pkg::ST_DATA);
                  end else if (cp_acc < 16'h0800) begin
                     emit({3'b110, cp_acc[10:6]}, jsu_pkg::ST_DATA);
                     emit({2'b10, cp_acc[5:0]}, jsu_pkg::ST_DATA);
                  end else begin
                     emit({4'b1110, cp_acc[15:12]}, jsu_pkg::ST_DATA);
                     emit({2'b10, cp_acc[11:6]}, jsu_pkg::ST_DATA);
                     emit({2'b10, cp_acc[5:0]}, jsu_pkg::ST_DATA);
                  end
                  dec_mode = jsu_pkg::MODE_STR;
                  hex_cnt  = 2'd0;
               end else begin
                  hex_cnt = hex_cnt + 2'd1;
               end
            end
         end
      endcase
      if (dec_mode == jsu_pkg::MODE_IDLE) begin
         hex_cnt = 2'd0;
         cp_acc  = 16'h0000;
      end
      for (i = 0; i < step_out.size(); i++) begin
         r           = step_out[i];
         r.last      = (i == step_out.size() - 1);
         decoded_due = {decoded_due, r};
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 30) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Offer one byte, wait for the transfer, then maybe leave a gap.
   task automatic send_byte(input logic [7:0] b, input logic lst);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      unescape_byte(b, lst);
      bytes_sent++;
      if (!calm && $urandom_range(0, 99) < 25) begin
         gap = gap_len();
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input logic last_at_end);
      int i;
      for (i = 0; i < s.len(); i++)
         send_byte(s[i], last_at_end && (i == s.len() - 1));
   endtask

   task automatic send_hex4(input logic [15:0] cp);
      int i;
      for (i = 3; i >= 0; i--)
         send_byte(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
   endtask

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      do b = rand_byte(); while (hex_nibble(b) != 5'b0_0000);
      return b;
   endfunction

   // One piece of string content: a plain byte, an escape or a \u form.
   task automatic send_token();
      int          kind;
      int          sel;
      logic [7:0]  b;
      logic [15:0] cp;
      kind = $urandom_range(0, 2);
      if (kind == 0) begin
         do b = rand_byte(); while (b == CH_QUOTE || b == CH_BSLASH);
         send_byte(b, 1'b0);
      end else if (kind == 1) begin
         sel = $urandom_range(0, 8);
         case (sel)
            0: b = 8'h62;
            1: b = 8'h66;
            2: b = 8'h6E;
            3: b = 8'h72;
            4: b = 8'h74;
            5: b = CH_QUOTE;
            6: b = CH_BSLASH;
            7: b = 8'h2F;
            default: do b = rand_byte(); while (b == CH_U);
         endcase
         send_byte(CH_BSLASH, 1'b0);
         send_byte(b, 1'b0);
      end else begin
         sel = $urandom_range(0, 2);
         cp  = 16'($urandom_range(0, 16'hFFFF));
         if (sel == 0) cp = cp & 16'h007F;
         else if (sel == 1) cp = cp & 16'h07FF;
         send_byte(CH_BSLASH, 1'b0);
         send_byte(CH_U, 1'b0);
         send_hex4(cp);
      end
   endtask

   task automatic send_string(input int n_tokens, input logic close_last);
      int i;
      // any byte flagged last puts the decoder back to idle
      if (dec_mode != jsu_pkg::MODE_IDLE) send_byte(rand_byte(), 1'b1);
      send_byte(CH_QUOTE, 1'b0);
      for (i = 0; i < n_tokens; i++) send_token();
      send_byte(CH_QUOTE, close_last);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (decoded_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---- result side ----
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 20) begin
            stall_left = gap_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result data=%02h status=%0d last=%0b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            head = decoded_due.pop_front();
            if (rsp_tdata !== head.data || rsp_tuser !== head.status ||
                rsp_tlast !== head.last)
               report_mismatch($sformatf(
                  "got data=%02h status=%0d last=%0b, want data=%02h status=%0d last=%0b",
                  rsp_tdata, rsp_tuser, rsp_tlast, head.data, head.status, head.last));
         end
      end
   end

   // ---- tests ----
   task automatic test_idle_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_QUOTE, 1'b1);   // opening quote is the final source byte
      send_byte(8'h7A, 1'b1);
      wait_drain();
   endtask

   task automatic test_escapes();
      send_byte(CH_QUOTE, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t\\q\"", 1'b0);
      wait_drain();
   endtask

   task automatic test_unicode();
      send_text("\"\\u0000\\u07fF\\uFFFF\"", 1'b0);
      wait_drain();
   endtask

   task automatic test_truncation();
      send_text("\"z", 1'b1);
      send_text("\"\\", 1'b1);
      send_text("\"\\t", 1'b1);
      send_text("\"\\u12", 1'b1);
      send_text("\"\\u1234", 1'b1);
      send_text("\"\\u1g", 1'b0);
      send_text("\"\\u\"", 1'b0);   // quote in a hex position
      send_text("\"\\uAbx", 1'b1);
      wait_drain();
   endtask

   task automatic test_backpressure();
      calm     = 1'b1;
      hold_req = 80;
      send_string(4, 1'b0);
      send_string(3, 1'b0);
      send_string(4, 1'b1);
      calm = 1'b0;
      wait_drain();
   endtask

   task automatic test_random();
      int start;
      int sel;
      int n;
      int i;
      start = bytes_sent;
      while (bytes_sent - start < 130) begin
         calm = ($urandom_range(0, 99) < 15);
         sel  = $urandom_range(0, 99);
         if (sel < 65) begin
            send_string($urandom_range(0, 8), $urandom_range(0, 9) == 0);
         end else if (sel < 80) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
               send_byte(rand_byte(), $urandom_range(0, 4) == 0);
         end else begin
            if (dec_mode != jsu_pkg::MODE_IDLE) send_byte(rand_byte(), 1'b1);
            send_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++) send_token();
            sel = $urandom_range(0, 2);
            if (sel == 0) begin
               send_byte(rand_byte(), 1'b1);
            end else begin
               send_byte(CH_BSLASH, 1'b0);
               send_byte(CH_U, 1'b0);
               n = $urandom_range(0, 3);
               for (i = 0; i < n; i++)
                  send_byte(hex_char(rand_nibble(), 1'($urandom_range(0, 1))), 1'b0);
               if (sel == 1)
                  send_byte(non_hex_byte(), 1'($urandom_range(0, 1)));
               else
                  send_byte(hex_char(rand_nibble(), 1'($urandom_range(0, 1))), 1'b1);
            end
         end
      end
      calm = 1'b0;
      wait_drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_bytes();
      test_escapes();
      test_unicode();
      test_truncation();
      test_backpressure();
      test_random();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && decoded_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
